### rtl/assert_macros.svh
// Assertion helpers shared by the RTL. They compile to nothing under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define WSP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: check failed");

// When the antecedent holds, the consequent must hold in the next cycle.
`define WSP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: check failed");

`else

`define WSP_ASSERT(lbl, clk, rstn, prop)
`define WSP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

### rtl/wsp_pkg.sv
package wsp_pkg;

  localparam int unsigned FRAC_BITS_DEF   = 16;
  localparam int unsigned COORD_WIDTH_DEF = 32;

  localparam int unsigned ELEM_WIDTH   = 32;
  localparam int unsigned POS_WIDTH    = 32;
  localparam int unsigned OUT_WIDTH    = 32;
  localparam int unsigned VEC_LEN      = 4;
  localparam int unsigned ELEM_PER_MAT = VEC_LEN * VEC_LEN;
  localparam int unsigned MAT_WORDS    = 2 * ELEM_PER_MAT;

  // Wide enough for any full product and for every saturation step.
  localparam int unsigned SAT_W = 96;
  typedef logic signed [SAT_W-1:0] wide_t;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_XFORM = 1'b1
  } cmd_e;

  typedef enum logic {
    MAT_VIEW = 1'b0,
    MAT_PROJ = 1'b1
  } mat_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DRAIN,
    ST_NEXT,
    ST_DIV,
    ST_OUT
  } wsp_state_e;

  typedef struct packed {
    logic issue;
    logic first;
    logic last;
  } mac_ctrl_t;

  // Clamp a value to the range of a w-bit signed number.
  function automatic wide_t sat_to(input wide_t v, input int unsigned w);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (w - 1)) - wide_t'(1);
    lo = ~hi;
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

endpackage

### rtl/wsp_ram.sv
module wsp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/wsp_mac.sv
module wsp_mac #(
  parameter int unsigned FRAC_BITS   = wsp_pkg::FRAC_BITS_DEF,
  parameter int unsigned COORD_WIDTH = wsp_pkg::COORD_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  wsp_pkg::mac_ctrl_t                ctrl_i,
  input  logic [wsp_pkg::ELEM_WIDTH-1:0]    coef_i,
  input  logic signed [COORD_WIDTH-1:0]     vec_i,
  output logic                              row_valid_o,
  output logic signed [COORD_WIDTH-1:0]     row_o
);

  import wsp_pkg::*;

  // The vector operand is split in two halves so each multiplier stays narrow.
  localparam int unsigned LO_W   = (COORD_WIDTH + 1) / 2;
  localparam int unsigned HI_W   = COORD_WIDTH - LO_W;
  localparam int unsigned LO_PW  = ELEM_WIDTH + LO_W + 1;
  localparam int unsigned HI_PW  = ELEM_WIDTH + HI_W;
  localparam int unsigned ACC_W  = COORD_WIDTH + 2;

  logic                      s1_v_q, s1_first_q, s1_last_q;
  logic signed [LO_PW-1:0]   pplo_q, pplo_d;
  logic signed [HI_PW-1:0]   pphi_q, pphi_d;

  logic                      s2_v_q, s2_first_q, s2_last_q;
  logic signed [COORD_WIDTH-1:0] sp_q, sp_d;
  wide_t                     prod;

  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic signed [ACC_W-1:0]   acc_base;
  logic                      row_valid_q;
  logic signed [COORD_WIDTH-1:0] row_q, row_d;

  always_comb begin
    pplo_d = $signed(coef_i) * $signed({1'b0, vec_i[LO_W-1:0]});
    pphi_d = $signed(coef_i) * $signed(vec_i[COORD_WIDTH-1:LO_W]);
  end

  always_comb begin
    prod = wide_t'(pplo_q) + (wide_t'(pphi_q) <<< LO_W);
    sp_d = COORD_WIDTH'(sat_to(prod >>> FRAC_BITS, COORD_WIDTH));
  end

  // Each product saturates on its own; the four products of a row then add exactly, and the row total saturates.
  always_comb begin
    if (s2_first_q) begin
      acc_base = '0;
    end else begin
      acc_base = acc_q;
    end
    acc_d = acc_base + ACC_W'(sp_q);
    row_d = COORD_WIDTH'(sat_to(wide_t'(acc_d), COORD_WIDTH));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      row_valid_q <= 1'b0;
    end else begin
      s1_v_q      <= ctrl_i.issue;
      s2_v_q      <= s1_v_q;
      row_valid_q <= s2_v_q && s2_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.issue) begin
      pplo_q     <= pplo_d;
      pphi_q     <= pphi_d;
      s1_first_q <= ctrl_i.first;
      s1_last_q  <= ctrl_i.last;
    end
    if (s1_v_q) begin
      sp_q       <= sp_d;
      s2_first_q <= s1_first_q;
      s2_last_q  <= s1_last_q;
    end
    if (s2_v_q) begin
      acc_q <= acc_d;
      if (s2_last_q) begin
        row_q <= row_d;
      end
    end
  end

  assign row_valid_o = row_valid_q;
  assign row_o       = row_q;

endmodule

### rtl/wsp_div.sv
module wsp_div #(
  parameter int unsigned FRAC_BITS   = wsp_pkg::FRAC_BITS_DEF,
  parameter int unsigned COORD_WIDTH = wsp_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [COORD_WIDTH-1:0] num_x_i,
  input  logic signed [COORD_WIDTH-1:0] num_y_i,
  input  logic signed [COORD_WIDTH-1:0] den_i,
  output logic                          done_o,
  output logic signed [COORD_WIDTH-1:0] quo_x_o,
  output logic signed [COORD_WIDTH-1:0] quo_y_o
);

  localparam int unsigned LANES = 2;
  localparam int unsigned QW    = COORD_WIDTH + FRAC_BITS;
  localparam int unsigned CNT_W = $clog2(QW + 1);
  localparam logic signed [COORD_WIDTH-1:0] MAXC = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] MINC = ~MAXC;

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [COORD_WIDTH-1:0] den_q, den_d;
  logic [QW-1:0]          sh_q [LANES];
  logic [QW-1:0]          sh_d [LANES];
  logic [COORD_WIDTH-1:0] rem_q [LANES];
  logic [COORD_WIDTH-1:0] rem_d [LANES];
  logic                   neg_q [LANES];
  logic                   neg_d [LANES];
  logic signed [COORD_WIDTH-1:0] num [LANES];
  logic signed [COORD_WIDTH-1:0] quo [LANES];

  assign num[0] = num_x_i;
  assign num[1] = num_y_i;

  // Restoring division, one quotient bit per cycle in both lanes. The shift
  // register starts as the dividend magnitude shifted left by FRAC_BITS and ends as the quotient.
  always_comb begin
    logic [COORD_WIDTH-1:0] mag;
    logic [COORD_WIDTH-1:0] rsh;
    logic                   ge;
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    den_d  = den_q;
    sh_d   = sh_q;
    rem_d  = rem_q;
    neg_d  = neg_q;
    mag    = '0;
    rsh    = '0;
    ge     = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(QW);
      den_d  = den_i;
      for (int l = 0; l < LANES; l++) begin
        neg_d[l] = num[l][COORD_WIDTH-1];
        if (num[l][COORD_WIDTH-1]) begin
          mag = COORD_WIDTH'(0) - num[l];
        end else begin
          mag = num[l];
        end
        sh_d[l]  = {mag, {FRAC_BITS{1'b0}}};
        rem_d[l] = '0;
      end
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
      for (int l = 0; l < LANES; l++) begin
        rsh      = {rem_q[l][COORD_WIDTH-2:0], sh_q[l][QW-1]};
        ge       = rsh >= den_q;
        rem_d[l] = ge ? rsh - den_q : rsh;
        sh_d[l]  = {sh_q[l][QW-2:0], ge};
      end
    end
  end

  // A quotient of 2^(COORD_WIDTH-1) or more clamps to the range ends.
  always_comb begin
    logic big;
    big = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      big = |sh_q[l][QW-1:COORD_WIDTH-1];
      if (neg_q[l]) begin
        quo[l] = big ? MINC : -$signed(sh_q[l][COORD_WIDTH-1:0]);
      end else begin
        quo[l] = big ? MAXC : $signed(sh_q[l][COORD_WIDTH-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q <= den_d;
    sh_q  <= sh_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
  end

  assign done_o  = done_q;
  assign quo_x_o = quo[0];
  assign quo_y_o = quo[1];

endmodule

### rtl/world_to_screen_projection.sv
// Channel   Direction  Handshake               Payload
// input     in         in_valid_i/in_stall_o   cmd, which_matrix, element_index,
//                                              element_value, pos_x, pos_y, pos_z
// output    out        out_valid_o/out_stall_i visible, screen_x, screen_y
//
// A matrix load gives no result. A transform is paced by the single read port
// of the coefficient memory (one element per cycle, 32 in all) and by the
// divider, which produces one quotient bit per cycle for x and y. A rejected
// point skips the divide.
// Both matrices read as identity after reset; no clearing pass is needed.
// Input is stalled while a transform is in flight; a result waits in the output
// register, and a new item is accepted while it waits.
`include "assert_macros.svh"

module world_to_screen_projection #(
  parameter int unsigned FRAC_BITS   = wsp_pkg::FRAC_BITS_DEF,
  parameter int unsigned COORD_WIDTH = wsp_pkg::COORD_WIDTH_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   cmd_i,
  input  logic                                   which_matrix_i,
  input  logic [3:0]                             element_index_i,
  input  logic signed [wsp_pkg::ELEM_WIDTH-1:0]  element_value_i,
  input  logic signed [wsp_pkg::POS_WIDTH-1:0]   pos_x_i,
  input  logic signed [wsp_pkg::POS_WIDTH-1:0]   pos_y_i,
  input  logic signed [wsp_pkg::POS_WIDTH-1:0]   pos_z_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic                                   visible_o,
  output logic signed [wsp_pkg::OUT_WIDTH-1:0]   screen_x_o,
  output logic signed [wsp_pkg::OUT_WIDTH-1:0]   screen_y_o
);

  import wsp_pkg::*;

  localparam int unsigned IDX_W  = $clog2(ELEM_PER_MAT);
  localparam int unsigned ADDR_W = $clog2(MAT_WORDS);
  localparam int unsigned ROW_W  = $clog2(VEC_LEN);
  localparam logic [ELEM_WIDTH-1:0] ELEM_ONE = ELEM_WIDTH'(1) << FRAC_BITS;
  localparam logic signed [COORD_WIDTH-1:0] COORD_ONE = COORD_WIDTH'(1) << FRAC_BITS;

  wsp_state_e state_q, state_d;
  mat_e       mat_q, mat_d;
  logic [IDX_W-1:0] k_q, k_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             rej_q, rej_d;
  logic             rdv_q;
  logic [IDX_W-1:0] rdk_q;
  logic             vld_rd_q;
  logic [MAT_WORDS-1:0] ent_vld_q;

  logic signed [COORD_WIDTH-1:0] vin_q  [VEC_LEN];
  logic signed [COORD_WIDTH-1:0] vin_d  [VEC_LEN];
  logic signed [COORD_WIDTH-1:0] vout_q [VEC_LEN];
  logic signed [COORD_WIDTH-1:0] vout_d [VEC_LEN];

  logic                   ram_we, ram_re;
  logic [ADDR_W-1:0]      ram_waddr, ram_raddr;
  logic [ELEM_WIDTH-1:0]  ram_rdata;
  logic [ELEM_WIDTH-1:0]  coef;

  mac_ctrl_t                     mac_ctrl;
  logic signed [COORD_WIDTH-1:0] mac_vec;
  logic                          row_vld;
  logic signed [COORD_WIDTH-1:0] row_val;

  logic                          div_start, div_done;
  logic signed [COORD_WIDTH-1:0] quo_x, quo_y;

  logic                          in_xfer, out_load;
  logic                          out_valid_q, out_valid_d;
  logic                          out_vis_q;
  logic signed [OUT_WIDTH-1:0]   out_sx_q, out_sy_q;
  logic signed [OUT_WIDTH-1:0]   sx, sy;
  logic signed [COORD_WIDTH-1:0] pos_sat [3];

  assign ram_waddr = {which_matrix_i, element_index_i};
  assign ram_raddr = {mat_q, k_q};

  wsp_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (MAT_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (element_value_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Entries never loaded read as identity: ones on the diagonal.
  always_comb begin
    if (vld_rd_q) begin
      coef = ram_rdata;
    end else if (rdk_q[ROW_W-1:0] == rdk_q[IDX_W-1:ROW_W]) begin
      coef = ELEM_ONE;
    end else begin
      coef = '0;
    end
  end

  assign mac_ctrl.issue = rdv_q;
  assign mac_ctrl.first = rdk_q[ROW_W-1:0] == '0;
  assign mac_ctrl.last  = &rdk_q[ROW_W-1:0];
  assign mac_vec        = vin_q[rdk_q[ROW_W-1:0]];

  wsp_mac #(
    .FRAC_BITS   (FRAC_BITS),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (mac_ctrl),
    .coef_i      (coef),
    .vec_i       (mac_vec),
    .row_valid_o (row_vld),
    .row_o       (row_val)
  );

  wsp_div #(
    .FRAC_BITS   (FRAC_BITS),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_x_i (vout_q[0]),
    .num_y_i (vout_q[1]),
    .den_i   (vout_q[3]),
    .done_o  (div_done),
    .quo_x_o (quo_x),
    .quo_y_o (quo_y)
  );

  always_comb begin
    pos_sat[0] = COORD_WIDTH'(sat_to(wide_t'(pos_x_i), COORD_WIDTH));
    pos_sat[1] = COORD_WIDTH'(sat_to(wide_t'(pos_y_i), COORD_WIDTH));
    pos_sat[2] = COORD_WIDTH'(sat_to(wide_t'(pos_z_i), COORD_WIDTH));
  end

  // Screen mapping: (ndc + 1) / 2 and (1 - ndc) / 2; the halving rounds down.
  always_comb begin
    wide_t tx;
    wide_t ty;
    tx = sat_to(wide_t'(quo_x) + wide_t'(COORD_ONE), COORD_WIDTH) >>> 1;
    ty = sat_to(wide_t'(COORD_ONE) - wide_t'(quo_y), COORD_WIDTH) >>> 1;
    sx = OUT_WIDTH'(sat_to(tx, OUT_WIDTH));
    sy = OUT_WIDTH'(sat_to(ty, OUT_WIDTH));
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && cmd_i == CMD_XFORM) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (&k_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (row_vld && &row_q) begin
          state_d = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (mat_q == MAT_VIEW) begin
          state_d = ST_MUL;
        end else if (vout_q[3] <= 0) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall_o = state_q != ST_IDLE;
    in_xfer    = in_valid_i && !in_stall_o;
    ram_we     = in_xfer && cmd_i == CMD_LOAD;
    ram_re     = state_q == ST_MUL;
    div_start  = state_q == ST_NEXT && mat_q == MAT_PROJ && vout_q[3] > 0;
    out_load   = state_q == ST_OUT && (!out_valid_q || !out_stall_i);
  end

  always_comb begin
    mat_d  = mat_q;
    k_d    = k_q;
    row_d  = row_q;
    rej_d  = rej_q;
    vin_d  = vin_q;
    vout_d = vout_q;
    if (in_xfer && cmd_i == CMD_XFORM) begin
      vin_d[0] = pos_sat[0];
      vin_d[1] = pos_sat[1];
      vin_d[2] = pos_sat[2];
      vin_d[3] = COORD_ONE;
      mat_d    = MAT_VIEW;
      k_d      = '0;
      row_d    = '0;
    end
    if (ram_re) begin
      k_d = k_q + 1'b1;
    end
    if (row_vld) begin
      vout_d[row_q] = row_val;
      row_d         = row_q + 1'b1;
    end
    if (state_q == ST_NEXT) begin
      if (mat_q == MAT_VIEW) begin
        vin_d = vout_q;
        mat_d = MAT_PROJ;
      end else begin
        rej_d = vout_q[3] <= 0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mat_q       <= MAT_VIEW;
      k_q         <= '0;
      row_q       <= '0;
      rej_q       <= 1'b0;
      rdv_q       <= 1'b0;
      ent_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mat_q       <= mat_d;
      k_q         <= k_d;
      row_q       <= row_d;
      rej_q       <= rej_d;
      rdv_q       <= ram_re;
      out_valid_q <= out_valid_d;
      if (ram_we) begin
        ent_vld_q[ram_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    vin_q  <= vin_d;
    vout_q <= vout_d;
    if (ram_re) begin
      rdk_q    <= k_q;
      vld_rd_q <= ent_vld_q[ram_raddr];
    end
    if (out_load) begin
      out_vis_q <= !rej_q;
      out_sx_q  <= rej_q ? '0 : sx;
      out_sy_q  <= rej_q ? '0 : sy;
    end
  end

  assign out_valid_o = out_valid_q;
  assign visible_o   = out_vis_q;
  assign screen_x_o  = out_sx_q;
  assign screen_y_o  = out_sy_q;

  `WSP_ASSERT(a_row_in_pass, clk_i, rst_ni, row_vld |-> (state_q == ST_MUL || state_q == ST_DRAIN))
  `WSP_ASSERT(a_div_done_in_div, clk_i, rst_ni, div_done |-> state_q == ST_DIV)
  `WSP_ASSERT(a_rows_complete, clk_i, rst_ni, (state_q == ST_NEXT) |-> row_q == '0)
  `WSP_ASSERT(a_reject_zero, clk_i, rst_ni, (out_valid_q && !out_vis_q) |-> (out_sx_q == '0 && out_sy_q == '0))
  `WSP_ASSERT_NEXT(a_xform_reads, clk_i, rst_ni, in_xfer && cmd_i == CMD_XFORM, ram_re && k_q == '0 && mat_q == MAT_VIEW)

endmodule
